// File: sv/source_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// source_tokenizer_assert
// Assertion macros for the source tokenizer; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define ST_ASSERT_IMPL(label, clk, rst, cond) \
    label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ST_ASSERT_NEXT(label, clk, rst, pre, post) \
    label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ST_ASSERT_IMPL(label, clk, rst, cond)
`define ST_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: sv/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Token kinds, scan modes and character classes of the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd57;
    localparam logic [5:0] K_NUMBER = 6'd58;
    localparam logic [5:0] K_STRING = 6'd59;
    localparam logic [5:0] K_CHAR   = 6'd60;
    localparam logic [5:0] K_ERROR  = 6'd61;

    typedef enum logic [10:0] {
        M_IDLE      = 11'b00000000001,
        M_OP1       = 11'b00000000010,
        M_OP2       = 11'b00000000100,
        M_DOT       = 11'b00000001000,
        M_IDENT     = 11'b00000010000,
        M_NUMBER    = 11'b00000100000,
        M_NUM_E     = 11'b00001000000,
        M_STRING    = 11'b00010000000,
        M_CHAR_OPEN = 11'b00100000000,
        M_CHAR_BODY = 11'b01000000000,
        M_HALT      = 11'b10000000000
    } mode_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] p);
        logic [5:0] k;
        unique case (p)
            "!": k = 6'd11;
            "+": k = 6'd15;
            "-": k = 6'd18;
            "=": k = 6'd20;
            ">": k = 6'd24;
            "<": k = 6'd28;
            "&": k = 6'd31;
            "|": k = 6'd34;
            "*": k = 6'd36;
            "/": k = 6'd38;
            default: k = 6'd40;
        endcase
        return k;
    endfunction

    // Zero when the two bytes form no operator.
    function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        if (c == "=") begin
            unique case (p)
                "!": k = 6'd12;
                "+": k = 6'd13;
                "-": k = 6'd16;
                "=": k = 6'd19;
                ">": k = 6'd23;
                "<": k = 6'd27;
                "&": k = 6'd29;
                "|": k = 6'd32;
                "*": k = 6'd35;
                "/": k = 6'd37;
                default: k = 6'd39;
            endcase
        end else if (c == p) begin
            unique case (p)
                "+": k = 6'd14;
                "-": k = 6'd17;
                "&": k = 6'd30;
                "|": k = 6'd33;
                default: k = 6'd0;
            endcase
        end
        return k;
    endfunction

    // Symbol kind for a byte that begins a token of its own.
    function automatic logic [5:0] symbol_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            ":": k = 6'd1;
            ";": k = 6'd2;
            ",": k = 6'd3;
            "(": k = 6'd4;
            ")": k = 6'd5;
            "{": k = 6'd6;
            "}": k = 6'd7;
            "[": k = 6'd8;
            "]": k = 6'd9;
            "~": k = 6'd10;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == "!" || c == "+" || c == "-" || c == "=" || c == ">" || c == "<" ||
               c == "&" || c == "|" || c == "*" || c == "/" || c == "%";
    endfunction

endpackage

// File: sv/stok_keyword.sv
// ----------------------------------------------------------------------------
// stok_keyword
// Matches the buffered identifier bytes against the sixteen keywords.
// ----------------------------------------------------------------------------
module stok_keyword #(
    parameter int KEYWORD_MAX = 9,
    parameter int LENGTH_BITS = 16
) (
    input  logic [KEYWORD_MAX-1:0][7:0] word,
    input  logic [LENGTH_BITS-1:0]      run_len,
    output logic [5:0]                  kind
);
    function automatic logic hit(input logic [KEYWORD_MAX-1:0][7:0] w,
                                 input logic [LENGTH_BITS-1:0] n,
                                 input logic [71:0] txt, input int len);
        logic ok;
        ok = (n == LENGTH_BITS'(len));
        for (int i = 0; i < 9; i++) begin
            if (i < len && i < KEYWORD_MAX) begin
                ok = ok && (w[i] == txt[8*(len-1-i) +: 8]);
            end
        end
        return ok;
    endfunction

    always_comb begin
        kind = stok_pkg::K_IDENT;
        priority if (hit(word, run_len, 72'("i8"), 2))         kind = 6'd41;
        else if (hit(word, run_len, 72'("u8"), 2))             kind = 6'd42;
        else if (hit(word, run_len, 72'("if"), 2))             kind = 6'd43;
        else if (hit(word, run_len, 72'("i16"), 3))            kind = 6'd44;
        else if (hit(word, run_len, 72'("i32"), 3))            kind = 6'd45;
        else if (hit(word, run_len, 72'("i64"), 3))            kind = 6'd46;
        else if (hit(word, run_len, 72'("u16"), 3))            kind = 6'd47;
        else if (hit(word, run_len, 72'("u32"), 3))            kind = 6'd48;
        else if (hit(word, run_len, 72'("u64"), 3))            kind = 6'd49;
        else if (hit(word, run_len, 72'("f32"), 3))            kind = 6'd50;
        else if (hit(word, run_len, 72'("f64"), 3))            kind = 6'd51;
        else if (hit(word, run_len, 72'("use"), 3))            kind = 6'd52;
        else if (hit(word, run_len, 72'("char"), 4))           kind = 6'd53;
        else if (hit(word, run_len, 72'("else"), 4))           kind = 6'd54;
        else if (hit(word, run_len, 72'("struct"), 6))         kind = 6'd55;
        else if (hit(word, run_len, 72'("namespace"), 9))      kind = 6'd56;
        else                                                   kind = stok_pkg::K_IDENT;
    end
endmodule

// File: sv/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one source byte in per word, zero to two tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one source byte (s_char_code) per word; byte 0
//   marks end of input. m_valid/m_ready carry tokens: kind, start offset,
//   length, char value and a last flag on the final token of a byte.
//   The byte is decoded in the cycle it is accepted; its tokens sit in a
//   two-entry output buffer and appear on m_* from the next cycle.
//   Throughput: one byte per cycle while the receiver takes every token.
//   A byte that yields two tokens holds s_ready low while the second token
//   drains, so the next byte waits for that drain.
//   The rate is set by the two-entry output buffer, not by the decode.
//   If the receiver stalls, the buffer fills and s_ready drops until
//   there is room for the worst case of two tokens.
//   After an end or error token, bytes are still accepted and dropped.
//   Reset (aresetn low, synchronous) clears the scan state, the byte
//   offset and the output buffer.
// ----------------------------------------------------------------------------
`include "source_tokenizer_assert.svh"
module source_tokenizer #(
    parameter int KEYWORD_MAX   = 9,
    parameter int LENGTH_BITS   = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [31:0] m_start_offset,
    output logic [15:0] m_token_length,
    output logic [6:0]  m_char_value,
    output logic        m_last
);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam int KI_BITS = $clog2(KEYWORD_MAX);

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [6:0]  cv;
        logic        last;
    } tok_t;

    stok_pkg::mode_t             mode_reg, mode_next;
    logic [7:0]                  pend_reg, pend_next;
    logic [KEYWORD_MAX-1:0][7:0] word_reg, word_next;
    logic [LENGTH_BITS-1:0]      rlen_reg, rlen_next;
    logic [POSITION_BITS-1:0]    rstart_reg, rstart_next;
    logic [POSITION_BITS-1:0]    pos_reg;
    logic [7:0]                  lit_reg, lit_next;

    tok_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       head_reg;

    tok_t       t0, t1;
    logic [1:0] n_emit;
    logic [5:0] kw_kind;
    logic       accept, pop;

    stok_keyword #(.KEYWORD_MAX(KEYWORD_MAX), .LENGTH_BITS(LENGTH_BITS)) u_kw (
        .word(word_reg), .run_len(rlen_reg), .kind(kw_kind)
    );

    assign s_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = cnt_reg != 2'd0;
    assign pop     = m_valid && m_ready;
    assign {m_token_kind, m_start_offset, m_token_length, m_char_value, m_last} =
        q_reg[head_reg];

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] x);
        return (x != LEN_MAX) ? x + 1'b1 : x;
    endfunction

    function automatic tok_t mk(input logic [5:0] k, input logic [POSITION_BITS-1:0] s,
                                input logic [LENGTH_BITS-1:0] l, input logic [7:0] v);
        tok_t t;
        t.kind  = k;
        t.start = 32'(s);
        t.len   = 16'(l);
        t.cv    = v[6:0];
        t.last  = 1'b0;
        return t;
    endfunction

    always_comb begin
        logic [7:0]  c;
        logic        again;
        logic [5:0]  pk;
        c           = s_char_code;
        again       = 1'b0;
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        word_next   = word_reg;
        rlen_next   = rlen_reg;
        rstart_next = rstart_reg;
        lit_next    = lit_reg;
        n_emit      = 2'd0;
        t0          = '0;
        t1          = '0;
        pk          = stok_pkg::pair_kind(pend_reg, c);
        unique case (mode_reg)
            stok_pkg::M_OP1: begin
                if ((pend_reg == ">" || pend_reg == "<") && c == pend_reg) begin
                    mode_next = stok_pkg::M_OP2;
                end else if (pk != 6'd0) begin
                    mode_next = stok_pkg::M_IDLE;
                    t0 = mk(pk, rstart_reg, LENGTH_BITS'(2), 8'd0);
                    n_emit = 2'd1;
                end else begin
                    mode_next = stok_pkg::M_IDLE;
                    t0 = mk(stok_pkg::single_kind(pend_reg), rstart_reg,
                            LENGTH_BITS'(1), 8'd0);
                    n_emit = 2'd1;
                    again = 1'b1;
                end
            end
            stok_pkg::M_OP2: begin
                mode_next = stok_pkg::M_IDLE;
                n_emit = 2'd1;
                if (c == "=") begin
                    t0 = mk((pend_reg == ">") ? 6'd21 : 6'd25, rstart_reg,
                            LENGTH_BITS'(3), 8'd0);
                end else begin
                    t0 = mk((pend_reg == ">") ? 6'd22 : 6'd26, rstart_reg,
                            LENGTH_BITS'(2), 8'd0);
                    again = 1'b1;
                end
            end
            stok_pkg::M_DOT: begin
                if (stok_pkg::is_digit(c)) begin
                    rlen_next = LENGTH_BITS'(2);
                    mode_next = stok_pkg::M_NUMBER;
                end else begin
                    t0 = mk(stok_pkg::K_ERROR, rstart_reg, LENGTH_BITS'(1), 8'd0);
                    n_emit = 2'd1;
                    mode_next = stok_pkg::M_HALT;
                end
            end
            stok_pkg::M_IDENT: begin
                if (stok_pkg::is_alpha(c) || stok_pkg::is_digit(c) || c == "_") begin
                    if (rlen_reg < LENGTH_BITS'(KEYWORD_MAX)) begin
                        word_next[rlen_reg[KI_BITS-1:0]] = c;
                    end
                    rlen_next = sat_inc(rlen_reg);
                end else begin
                    t0 = mk(kw_kind, rstart_reg, rlen_reg, 8'd0);
                    n_emit = 2'd1;
                    mode_next = stok_pkg::M_IDLE;
                    again = 1'b1;
                end
            end
            stok_pkg::M_NUMBER, stok_pkg::M_NUM_E: begin
                if (mode_reg == stok_pkg::M_NUM_E && (c == "+" || c == "-")) begin
                    rlen_next = sat_inc(rlen_reg);
                    mode_next = stok_pkg::M_NUMBER;
                end else if (stok_pkg::is_digit(c) || c == "." || c == "_") begin
                    rlen_next = sat_inc(rlen_reg);
                    mode_next = stok_pkg::M_NUMBER;
                end else if (stok_pkg::is_alpha(c)) begin
                    rlen_next = sat_inc(rlen_reg);
                    mode_next = (c == "e" || c == "E") ? stok_pkg::M_NUM_E
                                                       : stok_pkg::M_NUMBER;
                end else begin
                    t0 = mk(stok_pkg::K_NUMBER, rstart_reg, rlen_reg, 8'd0);
                    n_emit = 2'd1;
                    mode_next = stok_pkg::M_IDLE;
                    again = 1'b1;
                end
            end
            stok_pkg::M_STRING: begin
                rlen_next = sat_inc(rlen_reg);
                if (c == "\"") begin
                    t0 = mk(stok_pkg::K_STRING, rstart_reg, sat_inc(rlen_reg), 8'd0);
                    n_emit = 2'd1;
                    mode_next = stok_pkg::M_IDLE;
                end else if (c == 8'd0) begin
                    t0 = mk(stok_pkg::K_ERROR, rstart_reg, LENGTH_BITS'(1), 8'd0);
                    n_emit = 2'd1;
                    mode_next = stok_pkg::M_HALT;
                end
            end
            stok_pkg::M_CHAR_OPEN: begin
                if (c == 8'd0 || c[7]) begin
                    t0 = mk(stok_pkg::K_ERROR, rstart_reg, LENGTH_BITS'(1), 8'd0);
                    n_emit = 2'd1;
                    mode_next = stok_pkg::M_HALT;
                end else begin
                    lit_next = c;
                    mode_next = stok_pkg::M_CHAR_BODY;
                end
            end
            stok_pkg::M_CHAR_BODY: begin
                n_emit = 2'd1;
                if (c == "'") begin
                    t0 = mk(stok_pkg::K_CHAR, rstart_reg, LENGTH_BITS'(3), lit_reg);
                    mode_next = stok_pkg::M_IDLE;
                end else begin
                    t0 = mk(stok_pkg::K_ERROR, rstart_reg, LENGTH_BITS'(1), 8'd0);
                    mode_next = stok_pkg::M_HALT;
                end
            end
            stok_pkg::M_HALT: begin
                mode_next = stok_pkg::M_HALT;
            end
            default: begin
                mode_next = stok_pkg::M_IDLE;
                again = 1'b1;
            end
        endcase

        // Start a new token at this byte.
        if (again) begin
            tok_t ts;
            logic emit_s;
            emit_s = 1'b1;
            rstart_next = pos_reg;
            rlen_next = LENGTH_BITS'(1);
            ts = mk(stok_pkg::K_ERROR, pos_reg, LENGTH_BITS'(1), 8'd0);
            priority if (stok_pkg::is_space(c)) begin
                emit_s = 1'b0;
            end else if (c == 8'd0) begin
                ts.kind = stok_pkg::K_END;
                mode_next = stok_pkg::M_HALT;
            end else if (c == "\"") begin
                emit_s = 1'b0;
                mode_next = stok_pkg::M_STRING;
            end else if (c == "'") begin
                emit_s = 1'b0;
                mode_next = stok_pkg::M_CHAR_OPEN;
            end else if (stok_pkg::symbol_kind(c) != 6'd0) begin
                ts.kind = stok_pkg::symbol_kind(c);
            end else if (stok_pkg::is_op(c)) begin
                emit_s = 1'b0;
                pend_next = c;
                mode_next = stok_pkg::M_OP1;
            end else if (c == ".") begin
                emit_s = 1'b0;
                mode_next = stok_pkg::M_DOT;
            end else if (stok_pkg::is_alpha(c) || c == "_") begin
                emit_s = 1'b0;
                word_next[0] = c;
                mode_next = stok_pkg::M_IDENT;
            end else if (stok_pkg::is_digit(c)) begin
                emit_s = 1'b0;
                mode_next = stok_pkg::M_NUMBER;
            end else begin
                mode_next = stok_pkg::M_HALT;
            end
            if (emit_s) begin
                if (n_emit == 2'd0) begin
                    t0 = ts;
                end else begin
                    t1 = ts;
                end
                n_emit = n_emit + 2'd1;
            end
        end
        if (n_emit == 2'd1) t0.last = 1'b1;
        if (n_emit == 2'd2) t1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= stok_pkg::M_IDLE;
            pend_reg   <= '0;
            rlen_reg   <= '0;
            rstart_reg <= '0;
            pos_reg    <= '0;
            lit_reg    <= '0;
        end else if (accept && mode_reg != stok_pkg::M_HALT) begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            rlen_reg   <= rlen_next;
            rstart_reg <= rstart_next;
            pos_reg    <= pos_reg + 1'b1;
            lit_reg    <= lit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && mode_reg != stok_pkg::M_HALT) begin
            word_reg <= word_next;
        end
    end

    // Output buffer: two entries, head pointer and count.
    always_ff @(posedge aclk) begin
        logic [1:0] n_in;
        logic       wp;
        n_in = (accept && mode_reg != stok_pkg::M_HALT) ? n_emit : 2'd0;
        if (!aresetn) begin
            cnt_reg  <= '0;
            head_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_reg + n_in - {1'b0, pop};
            head_reg <= head_reg ^ pop;
        end
        wp = head_reg ^ cnt_reg[0];
        if (n_in != 2'd0) begin
            q_reg[wp] <= t0;
        end
        if (n_in == 2'd2) begin
            q_reg[~wp] <= t1;
        end
    end

    `ST_ASSERT_IMPL(a_cnt_range, aclk, !aresetn, cnt_reg <= 2'd2)
    `ST_ASSERT_NEXT(a_halt_stays, aclk, !aresetn, mode_reg == stok_pkg::M_HALT, mode_reg == stok_pkg::M_HALT)
    `ST_ASSERT_IMPL(a_full_blocks, aclk, !aresetn, cnt_reg == 2'd2 |-> !s_ready)
    `ST_ASSERT_NEXT(a_emit_shows, aclk, !aresetn, accept && mode_reg != stok_pkg::M_HALT && n_emit != 2'd0, m_valid)
endmodule
